FILE: rtl/histogram_equalizer_assert.svh
// Assertion macros used by the histogram equalizer datapath.
`ifndef HISTOGRAM_EQUALIZER_ASSERT_SVH
`define HISTOGRAM_EQUALIZER_ASSERT_SVH

// Same-cycle check: whenever ante holds, cons holds too.
`define HISTEQ_CHECK(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle check: whenever ante holds, cons holds in the cycle after.
`define HISTEQ_CHECK_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/histeq_pkg.sv
// Shared constants and control/status types of the histogram equalizer.
`default_nettype none

package histeq_pkg;

   // Pixel and histogram geometry
   localparam int PIXEL_WIDTH    = 8;
   localparam int NUM_BINS       = 1 << PIXEL_WIDTH;
   localparam int BIN_ADDR_WIDTH = PIXEL_WIDTH;

   // Width of bin counters and of the pixel total (legal range 10 to 32)
   localparam int COUNT_WIDTH = 22;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Divider: numerator = 2*(2^PIXEL_WIDTH - 1)*cum + total, divisor = 2*total
   localparam int QUOT_WIDTH = PIXEL_WIDTH;
   localparam int NUM_WIDTH  = COUNT_WIDTH + PIXEL_WIDTH + 1;
   localparam int DSH_WIDTH  = COUNT_WIDTH + PIXEL_WIDTH;
   localparam int DIV_STEPS  = QUOT_WIDTH;
   localparam int STEP_WIDTH = $clog2(DIV_STEPS);

   // Operation codes on the request channel
   localparam logic OP_COUNT = 1'b0;
   localparam logic OP_MAP   = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                      count_go;
      logic                      map_go;
      logic                      bin_rd;
      logic                      acc;
      logic                      num_load;
      logic                      div_step;
      logic                      tbl_wr;
      logic                      finish;
      logic [BIN_ADDR_WIDTH-1:0] bin_idx;
   } histeq_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic rsp_free;
      logic total_zero;
   } histeq_status_type;

endpackage

`default_nettype wire

FILE: rtl/histeq_channels.sv
// Request and response channel interfaces of the histogram equalizer.
`default_nettype none

interface histeq_req_if;
   import histeq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   op;
   logic [PIXEL_WIDTH-1:0] pixel;
   logic                   last;

   modport source (output valid, output op, output pixel, output last, input ready);
   modport sink   (input valid, input op, input pixel, input last, output ready);
endinterface

interface histeq_rsp_if;
   import histeq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [PIXEL_WIDTH-1:0] mapped_pixel;

   modport source (output valid, output mapped_pixel, input ready);
   modport sink   (input valid, input mapped_pixel, output ready);
endinterface

`default_nettype wire

FILE: rtl/histeq_ram.sv
// Generic simple dual-port RAM: one write and one registered read per cycle.
`default_nettype none

module histeq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic [ADDR_WIDTH-1:0] waddr,
   input  wire logic [WIDTH-1:0]      wdata,
   input  wire logic                  re,
   input  wire logic [ADDR_WIDTH-1:0] raddr,
   output logic      [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/histeq_ctrl.sv
// Controller of the histogram equalizer: request handshake and table-build sequencer.
`default_nettype none

module histeq_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_op,
   input  wire logic                          req_last,
   output logic                               req_ready,
   input  wire histeq_pkg::histeq_status_type status,
   output histeq_pkg::histeq_cmd_type         cmd
);
   import histeq_pkg::*;

   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_DRAIN = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_ACC   = 3'd3;
   localparam logic [2:0] ST_NUM   = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_WRITE = 3'd6;

   localparam logic [STEP_WIDTH-1:0]     STEP_LAST = STEP_WIDTH'(DIV_STEPS - 1);
   localparam logic [BIN_ADDR_WIDTH-1:0] BIN_LAST  = BIN_ADDR_WIDTH'(NUM_BINS - 1);

   logic [2:0]                state_ff, state_in;
   logic [BIN_ADDR_WIDTH-1:0] idx_ff, idx_in;
   logic [STEP_WIDTH-1:0]     step_ff, step_in;
   logic                      ready_w;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      step_in     = step_ff;
      ready_w     = 1'b0;
      cmd         = '0;
      cmd.bin_idx = idx_ff;
      case (state_ff)
         ST_RUN: begin
            ready_w = (req_op == OP_COUNT) || status.rsp_free;
            if (req_valid && ready_w) begin
               if (req_op == OP_COUNT) begin
                  cmd.count_go = 1'b1;
                  if (req_last) begin
                     state_in = ST_DRAIN;
                  end
               end else begin
                  cmd.map_go = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            // let the final bin write land before the sweep reads it
            idx_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.bin_rd = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (idx_ff == '0 || status.total_zero) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            cmd.num_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_WIDTH'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.tbl_wr = 1'b1;
            if (idx_ff == BIN_LAST) begin
               cmd.finish = 1'b1;
               state_in   = ST_RUN;
            end else begin
               idx_in   = idx_ff + BIN_ADDR_WIDTH'(1);
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign req_ready = ready_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         idx_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/histeq_dp.sv
// Datapath of the histogram equalizer: bin and table RAMs, total, cumulative sum, divider.
`default_nettype none
`include "histogram_equalizer_assert.svh"

module histeq_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire histeq_pkg::histeq_cmd_type            cmd,
   input  wire logic [histeq_pkg::PIXEL_WIDTH-1:0]    req_pixel,
   output histeq_pkg::histeq_status_type              status,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic      [histeq_pkg::PIXEL_WIDTH-1:0]    rsp_mapped_pixel
);
   import histeq_pkg::*;

   // Bin valid bits: a bin that is not valid reads as zero
   logic [NUM_BINS-1:0]       bin_valid_ff, bin_valid_in;
   logic [COUNT_WIDTH-1:0]    total_ff, total_in;

   // Count pipeline: read at accept, write in the cycle after
   logic                      wr_pend_ff, wr_pend_in;
   logic [BIN_ADDR_WIDTH-1:0] wr_addr_ff;
   logic                      fwd_valid_ff;
   logic [BIN_ADDR_WIDTH-1:0] fwd_addr_ff;
   logic [COUNT_WIDTH-1:0]    fwd_data_ff;

   // Table build
   logic [COUNT_WIDTH-1:0]    cum_ff, cum_in;
   logic [NUM_WIDTH-1:0]      rem_ff, rem_in;
   logic [DSH_WIDTH-1:0]      dsh_ff, dsh_in;
   logic [QUOT_WIDTH-1:0]     quot_ff, quot_in;

   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      bin_re;
   logic [BIN_ADDR_WIDTH-1:0] bin_raddr;
   logic [COUNT_WIDTH-1:0]    bin_rdata;
   logic [COUNT_WIDTH-1:0]    bin_base;
   logic [COUNT_WIDTH-1:0]    bin_next;
   logic [COUNT_WIDTH-1:0]    acc_bin;
   logic                      fwd_hit;
   logic                      total_sat;
   logic                      count_take;
   logic                      div_ge;
   logic [NUM_WIDTH-1:0]      num_val;

   assign total_sat  = (total_ff == COUNT_MAX);
   assign count_take = cmd.count_go && !total_sat;

   assign bin_re    = cmd.count_go || cmd.bin_rd;
   assign bin_raddr = cmd.count_go ? req_pixel : cmd.bin_idx;

   // Forward the previous write when it hit the same bin
   assign fwd_hit  = fwd_valid_ff && (fwd_addr_ff == wr_addr_ff);
   assign bin_base = fwd_hit ? fwd_data_ff :
                     (bin_valid_ff[wr_addr_ff] ? bin_rdata : '0);
   assign bin_next = bin_base + COUNT_WIDTH'(1);

   assign acc_bin = bin_valid_ff[cmd.bin_idx] ? bin_rdata : '0;

   // 2*(2^PIXEL_WIDTH - 1)*cum + total, ties of the rounding go up
   assign num_val = (NUM_WIDTH'(cum_ff) << (PIXEL_WIDTH + 1))
                  - (NUM_WIDTH'(cum_ff) << 1)
                  + NUM_WIDTH'(total_ff);

   assign div_ge = (rem_ff >= NUM_WIDTH'(dsh_ff));

   histeq_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_BINS)
   ) u_bin_ram (
      .clock (clock),
      .we    (wr_pend_ff),
      .waddr (wr_addr_ff),
      .wdata (bin_next),
      .re    (bin_re),
      .raddr (bin_raddr),
      .rdata (bin_rdata)
   );

   histeq_ram #(
      .WIDTH (PIXEL_WIDTH),
      .DEPTH (NUM_BINS)
   ) u_map_ram (
      .clock (clock),
      .we    (cmd.tbl_wr),
      .waddr (cmd.bin_idx),
      .wdata (quot_ff),
      .re    (cmd.map_go),
      .raddr (req_pixel),
      .rdata (rsp_mapped_pixel)
   );

   always_comb begin
      bin_valid_in = bin_valid_ff;
      if (wr_pend_ff) begin
         bin_valid_in[wr_addr_ff] = 1'b1;
      end
      if (cmd.finish) begin
         bin_valid_in = '0;
      end

      total_in = total_ff;
      if (cmd.finish) begin
         total_in = '0;
      end else if (count_take) begin
         total_in = total_ff + COUNT_WIDTH'(1);
      end

      wr_pend_in = count_take;

      rsp_valid_in = rsp_valid_ff;
      if (cmd.map_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      cum_in = cum_ff;
      if (cmd.acc) begin
         cum_in = ((cmd.bin_idx == '0) ? '0 : cum_ff) + acc_bin;
      end

      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (cmd.acc) begin
         quot_in = '0;
      end else if (cmd.num_load) begin
         rem_in  = num_val;
         dsh_in  = DSH_WIDTH'(total_ff) << PIXEL_WIDTH;
         quot_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = div_ge ? (rem_ff - NUM_WIDTH'(dsh_ff)) : rem_ff;
         dsh_in  = dsh_ff >> 1;
         quot_in = {quot_ff[QUOT_WIDTH-2:0], div_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_valid_ff <= '0;
         total_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bin_valid_ff <= bin_valid_in;
         total_ff     <= total_in;
         wr_pend_ff   <= wr_pend_in;
         fwd_valid_ff <= wr_pend_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.count_go) begin
         wr_addr_ff <= req_pixel;
      end
      fwd_addr_ff <= wr_addr_ff;
      fwd_data_ff <= bin_next;
      cum_ff      <= cum_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quot_ff     <= quot_in;
   end

   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign status.total_zero = (total_ff == '0);
   assign rsp_valid         = rsp_valid_ff;

   `HISTEQ_CHECK(a_div_rem_bound, cmd.div_step, (rem_ff >> 1) < NUM_WIDTH'(dsh_ff), "divider remainder out of range")
   `HISTEQ_CHECK(a_build_no_count, cmd.div_step || cmd.tbl_wr, !wr_pend_ff, "bin write pending during table build")
   `HISTEQ_CHECK(a_cum_le_total, cmd.div_step, cum_ff <= total_ff, "cumulative count exceeds pixel total")
   `HISTEQ_CHECK_NEXT(a_finish_clears, cmd.finish, total_ff == '0 && bin_valid_ff == '0, "histogram not cleared after build")

endmodule

`default_nettype wire

FILE: rtl/histogram_equalizer.sv
// Top level of the 8-bit histogram equalizer.
`default_nettype none

// Histogram equalizer for one 8-bit grayscale image at a time. Count beats (op = count) add
// their pixel to a 256-bin histogram and bump a saturating pixel total; once the total sits
// at its maximum, further pixels are dropped but their last flag still ends the pass. Count
// beats are taken one per cycle: the bin RAM is read on the accepting edge and written back
// on the next, with the previous write forwarded when two beats hit the same bin. Map beats
// (op = map) read the mapping table and return one rsp beat in the following cycle; a map
// beat is taken one per cycle as long as the response register is empty or being drained. A
// count beat with last set stalls req for the table build: a drain step, then per bin a read
// and an accumulate, for every bin but bin 0 (and only when the pass counted pixels) a
// numerator load and eight divider steps, and a table write. The restoring divider produces
// one quotient bit per cycle. Each table entry is round(255 * cum / total) with ties rounded
// up, entry 0 is zero, and the histogram and total are cleared at the end of the build.
// Mapping a pixel before the first build returns an undefined value.
module histogram_equalizer (
   input  wire logic   clock,
   input  wire logic   reset,
   histeq_req_if.sink  req_ch,
   histeq_rsp_if.source rsp_ch
);
   import histeq_pkg::*;

   histeq_cmd_type    cmd;
   histeq_status_type status;

   // Sequencer: owns req ready and steps the table build bin by bin
   histeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic: bins, total, divider, mapping table, response register
   histeq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_pixel        (req_ch.pixel),
      .status           (status),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_mapped_pixel (rsp_ch.mapped_pixel)
   );

endmodule

`default_nettype wire
